>>> rtl/chps_pkg.sv
// chps_pkg: shared types, constants and helpers for the closest hash pair search unit
// depends on nothing; every other file of the block but chps_ram refers to it by scoped names

package chps_pkg;

    // field widths
    localparam int HASH_W  = 64;
    localparam int MODE_W  = 2;
    localparam int INDEX_W = 16;
    localparam int DIST_W  = 7;

    // distance that means no pair seen yet
    localparam logic [DIST_W-1:0] DIST_NONE = 7'd64;

    // defaults
    localparam int                WINDOW_DEPTH_DEF = 64;
    localparam logic [DIST_W-1:0] THRESHOLD_RESET  = 7'd4;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // input mode codes
    localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

    // work handed from front to back
    typedef enum logic [1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_SEARCH = 2'd2
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [HASH_W-1:0]  hash_value;
        logic [INDEX_W-1:0] base_a;
        logic [INDEX_W-1:0] base_b;
    } cmd_t;

    // population count of one byte
    function automatic logic [3:0] popcount8(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + {3'd0, b[i]};
        end
        return n;
    endfunction

endpackage

>>> rtl/chps_in_if.sv
// chps_in_if: request channel of the closest hash pair search unit
// depends on chps_pkg for field widths

interface chps_in_if;
    logic                         valid;
    logic                         ready;
    logic [chps_pkg::MODE_W-1:0]  mode;
    logic [chps_pkg::HASH_W-1:0]  hash_value;
    logic [chps_pkg::INDEX_W-1:0] base_a;
    logic [chps_pkg::INDEX_W-1:0] base_b;

    modport source (output valid, output mode, output hash_value, output base_a,
                    output base_b, input ready);
    modport sink (input valid, input mode, input hash_value, input base_a,
                  input base_b, output ready);
endinterface

>>> rtl/chps_out_if.sv
// chps_out_if: result channel of the closest hash pair search unit
// depends on chps_pkg for field widths

interface chps_out_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [chps_pkg::INDEX_W-1:0] index_a;
    logic [chps_pkg::INDEX_W-1:0] index_b;
    logic [chps_pkg::DIST_W-1:0]  best_distance;

    modport source (output valid, output found, output index_a, output index_b,
                    output best_distance, input ready);
    modport sink (input valid, input found, input index_a, input index_b,
                  input best_distance, output ready);
endinterface

>>> rtl/chps_ram.sv
// chps_ram: generic single write port, single read port ram with registered read
// depends on nothing

module chps_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/chps_front.sv
// chps_front: accepts request beats, turns the mode into a command, queues it for the back
// depends on chps_pkg and chps_in_if

module chps_front (
    input  logic           clk,
    input  logic           rst_n,
    chps_in_if.sink        req,
    output logic           cmd_valid,
    output chps_pkg::cmd_t cmd,
    input  logic           cmd_pop
);

    localparam int QD  = chps_pkg::QUEUE_DEPTH;
    localparam int QAW = (QD > 1) ? $clog2(QD) : 1;
    localparam int QCW = $clog2(QD + 1);

    chps_pkg::cmd_t entry_reg [QD];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] cnt_reg, cnt_next;

    logic           accept;
    logic           push;
    logic           pop;
    chps_pkg::cmd_t new_cmd;

    assign req.ready = (cnt_reg < QCW'(QD));
    assign accept    = req.valid && req.ready;

    // classify the beat; the unused mode is taken and dropped
    always_comb
    begin
        new_cmd.hash_value = req.hash_value;
        new_cmd.base_a     = req.base_a;
        new_cmd.base_b     = req.base_b;
        new_cmd.op         = chps_pkg::OP_SEARCH;
        push               = accept;
        unique case (req.mode)
            chps_pkg::MODE_LOAD_A: new_cmd.op = chps_pkg::OP_LOAD_A;
            chps_pkg::MODE_LOAD_B: new_cmd.op = chps_pkg::OP_LOAD_B;
            chps_pkg::MODE_SEARCH: new_cmd.op = chps_pkg::OP_SEARCH;
            default:               push       = 1'b0;
        endcase
    end

    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = entry_reg[rd_ptr_reg];
    assign pop       = cmd_pop && cmd_valid;

    // queue pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QD - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QD - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

>>> rtl/chps_back.sv
// chps_back: window loads, the pair walk with a pipelined distance unit, and the result register
// depends on chps_pkg, chps_ram and chps_out_if

module chps_back #(
    parameter int WINDOW_DEPTH = chps_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [chps_pkg::DIST_W-1:0] cfg_wdata,
    input  logic                        cmd_valid,
    input  chps_pkg::cmd_t              cmd,
    output logic                        cmd_pop,
    chps_out_if.source                  rsp
);

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int HW = chps_pkg::HASH_W;
    localparam int IW = chps_pkg::INDEX_W;
    localparam int DW = chps_pkg::DIST_W;
    localparam int NB = HW / 8;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic [DW-1:0]   thr_reg;
    logic [CW-1:0]   count_a_reg, count_a_next;
    logic [CW-1:0]   count_b_reg, count_b_next;
    logic [CW-1:0]   x_reg, x_next;
    logic [CW-1:0]   y_reg, y_next;
    logic [IW-1:0]   base_a_reg, base_b_reg;

    // distance pipeline
    logic            s1_vld_reg, s1_vld_next;
    logic [AW-1:0]   s1_x_reg, s1_y_reg;
    logic            s2_vld_reg;
    logic [AW-1:0]   s2_x_reg, s2_y_reg;
    logic [3:0]      s2_cnt_reg [NB];
    logic [DW-1:0]   pair_dist;

    // running best pair
    logic [DW-1:0]   best_reg, best_next;
    logic [AW-1:0]   bx_reg, bx_next;
    logic [AW-1:0]   by_reg, by_next;

    // result register
    logic            out_valid_reg, out_valid_next;
    logic            out_found_reg;
    logic [IW-1:0]   out_index_a_reg, out_index_b_reg;
    logic [DW-1:0]   out_dist_reg;
    logic            out_load;

    // window stores
    logic            we_a, we_b;
    logic [HW-1:0]   rdata_a, rdata_b;
    logic [HW-1:0]   diff;
    logic            start_search;
    logic            last_pair;
    logic            hit;
    logic            any_pair;

    chps_ram #(.WIDTH(HW), .DEPTH(WINDOW_DEPTH)) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (count_a_reg[AW-1:0]),
        .wdata (cmd.hash_value),
        .raddr (x_reg[AW-1:0]),
        .rdata (rdata_a)
    );

    chps_ram #(.WIDTH(HW), .DEPTH(WINDOW_DEPTH)) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (count_b_reg[AW-1:0]),
        .wdata (cmd.hash_value),
        .raddr (y_reg[AW-1:0]),
        .rdata (rdata_b)
    );

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= chps_pkg::THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    // command decode in idle
    assign cmd_pop      = (state_reg == ST_IDLE) && cmd_valid;
    assign we_a         = cmd_pop && (cmd.op == chps_pkg::OP_LOAD_A)
                          && (count_a_reg < CW'(WINDOW_DEPTH));
    assign we_b         = cmd_pop && (cmd.op == chps_pkg::OP_LOAD_B)
                          && (count_b_reg < CW'(WINDOW_DEPTH));
    assign start_search = cmd_pop && (cmd.op == chps_pkg::OP_SEARCH);

    assign any_pair  = (count_a_reg != '0) && (count_b_reg != '0);
    assign last_pair = (x_reg + 1'b1 == count_a_reg) && (y_reg + 1'b1 == count_b_reg);
    assign out_load  = (state_reg == ST_EMIT) && (!out_valid_reg || rsp.ready);

    // sequencer and pair walk
    always_comb
    begin
        state_next   = state_reg;
        count_a_next = count_a_reg;
        count_b_next = count_b_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        s1_vld_next  = 1'b0;
        if (we_a)
        begin
            count_a_next = count_a_reg + 1'b1;
        end
        if (we_b)
        begin
            count_b_next = count_b_reg + 1'b1;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_search)
                begin
                    x_next     = '0;
                    y_next     = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                // stop on an empty window or once a zero distance is in
                if (!any_pair || best_reg == '0)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    s1_vld_next = 1'b1;
                    if (last_pair)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else if (y_reg + 1'b1 == count_b_reg)
                    begin
                        y_next = '0;
                        x_next = x_reg + 1'b1;
                    end
                    else
                    begin
                        y_next = y_reg + 1'b1;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (!s1_vld_reg && !s2_vld_reg)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    count_a_next = '0;
                    count_b_next = '0;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // distance: byte counts are registered, then summed at the compare
    assign diff = rdata_a ^ rdata_b;

    always_comb
    begin
        pair_dist = '0;
        for (int i = 0; i < NB; i++)
        begin
            pair_dist = pair_dist + DW'(s2_cnt_reg[i]);
        end
    end

    // keep the first pair with the strictly smallest distance
    assign hit = s2_vld_reg && (pair_dist < best_reg);

    always_comb
    begin
        best_next = best_reg;
        bx_next   = bx_reg;
        by_next   = by_reg;
        if (start_search)
        begin
            best_next = chps_pkg::DIST_NONE;
            bx_next   = '0;
            by_next   = '0;
        end
        else if (hit)
        begin
            best_next = pair_dist;
            bx_next   = s2_x_reg;
            by_next   = s2_y_reg;
        end
    end

    assign out_valid_next = out_load ? 1'b1 : (out_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_a_reg   <= count_a_next;
            count_b_reg   <= count_b_next;
            s1_vld_reg    <= s1_vld_next;
            s2_vld_reg    <= s1_vld_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        s1_x_reg <= x_reg[AW-1:0];
        s1_y_reg <= y_reg[AW-1:0];
        s2_x_reg <= s1_x_reg;
        s2_y_reg <= s1_y_reg;
        for (int i = 0; i < NB; i++)
        begin
            s2_cnt_reg[i] <= chps_pkg::popcount8(diff[8*i +: 8]);
        end
        best_reg <= best_next;
        bx_reg   <= bx_next;
        by_reg   <= by_next;
        if (start_search)
        begin
            base_a_reg <= cmd.base_a;
            base_b_reg <= cmd.base_b;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_dist_reg <= best_reg;
            if (best_reg < chps_pkg::DIST_NONE)
            begin
                out_found_reg   <= (best_reg == '0) || (best_reg < thr_reg);
                out_index_a_reg <= base_a_reg + IW'(bx_reg);
                out_index_b_reg <= base_b_reg + IW'(by_reg);
            end
            else
            begin
                out_found_reg   <= 1'b0;
                out_index_a_reg <= '0;
                out_index_b_reg <= '0;
            end
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.found         = out_found_reg;
    assign rsp.index_a       = out_index_a_reg;
    assign rsp.index_b       = out_index_b_reg;
    assign rsp.best_distance = out_dist_reg;

endmodule

>>> rtl/closest_hash_pair_search_unit.sv
// closest_hash_pair_search_unit: top level of the closest hash pair search
// depends on chps_pkg, chps_in_if, chps_out_if, chps_front, chps_back, chps_ram

// Loads 64-bit frame hashes into window A (mode 0) or window B (mode 1) and, on a
// search beat (mode 2), walks every pair A-major and returns one result beat with
// the first pair of smallest Hamming distance; the search empties both windows.
// Request beats land in a two-entry command queue, so the request side keeps
// moving while the back end is busy, until both entries are full. A load is
// written into its window as the back end takes its command. A search issues one
// pair per cycle into a three-stage distance pipeline (ram read, byte counts, sum
// and compare), count_a * count_b pairs, at most 4096 with full windows of 64;
// it stops once a zero-distance pair is recorded and issues none when a window
// is empty; the pipeline then drains and the result waits in an output register
// while the next loads are already queued. match_threshold is written through
// cfg_we/cfg_wdata, by the user while the block is idle; it is not enforced.

module closest_hash_pair_search_unit #(
    parameter int WINDOW_DEPTH = chps_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [chps_pkg::DIST_W-1:0] cfg_wdata,
    chps_in_if.sink                     req,
    chps_out_if.source                  rsp
);

    logic           cmd_valid;
    logic           cmd_pop;
    chps_pkg::cmd_t cmd;

    // accept and queue
    chps_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // execute loads and searches
    chps_back #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .rsp       (rsp)
    );

endmodule
